// File: hdl/rar_pkg.sv
// Package for the ring all-reduce node: field widths, item kind codes,
// register indexes, internal operation codes and the control word type.
// No dependencies.
`default_nettype none

package rar_pkg;

    localparam int MAX_RANKS_DEF = 16;
    localparam int MAX_BLOCK_DEF = 256;

    localparam int KIND_W     = 2;
    localparam int IDX_W      = 12;
    localparam int VAL_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int RS_W       = 5;
    localparam int NR_W       = 4;
    localparam int BL_W       = 9;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RECV = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_RANK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN = 2'd2;

    // pipeline operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD = 3'd1;
    localparam logic [OP_W-1:0] OP_SEND = 3'd2;
    localparam logic [OP_W-1:0] OP_RSUM = 3'd3;
    localparam logic [OP_W-1:0] OP_GATH = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            rd;    // reads the local vector
        logic            fwd;   // all-gather word goes downstream
        logic            done;  // last word of the round
    } ctl_t;

    function automatic logic op_writes(input logic [OP_W-1:0] op);
        op_writes = (op == OP_LOAD) || (op == OP_RSUM) || (op == OP_GATH);
    endfunction

endpackage

`default_nettype wire

// File: hdl/rar_seq.sv
// Round sequencer: config registers, phase/step/element counters and
// the per-word address and operation decode. Depends on rar_pkg.
`default_nettype none

module rar_seq import rar_pkg::*; #(
    parameter int MAX_RANKS = MAX_RANKS_DEF,
    parameter int MAX_BLOCK = MAX_BLOCK_DEF,
    parameter int AW        = $clog2(MAX_RANKS * MAX_BLOCK)
) (
    input  wire logic                  clk,
    input  wire logic                  rstn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  accept,
    input  wire logic [KIND_W-1:0]     s_kind,
    input  wire logic [IDX_W-1:0]      s_elem_index,
    output ctl_t                       ctl,
    output logic [AW-1:0]              pos
);

    localparam int PW = $clog2(MAX_RANKS + 1);
    localparam int RW = $clog2(MAX_RANKS);
    localparam int BW = $clog2(MAX_BLOCK + 1);
    localparam int LW = $clog2(MAX_RANKS * MAX_BLOCK + 1);
    localparam int EW = (LW > IDX_W) ? LW : IDX_W;
    localparam int TW = PW + 1;
    localparam int OW = RW + BW + 1;

    logic [RS_W-1:0] rs_reg, rs_next;
    logic [NR_W-1:0] nr_reg, nr_next;
    logic [BL_W-1:0] blr_reg, blr_next;
    logic [PW-1:0]   p_reg, p_next;
    logic [BW-1:0]   bl_reg, bl_next;
    logic [RW-1:0]   r_reg, r_next;
    logic [LW-1:0]   lim_reg, lim_next;
    logic            cfg_hit;
    logic [7:0]      p8;
    logic [12:0]     b13;
    logic [11:0]     rem;

    logic            phase_reg;
    logic [PW-1:0]   step_reg;
    logic [BW-1:0]   recv_reg;
    logic [BW-1:0]   own_reg;

    logic [TW-1:0]   r_t, p_t, s_t, t0, t1, step_inc;
    logic [RW-1:0]   blk;
    logic [BW-1:0]   cnt;
    logic [OW-1:0]   off;
    logic [EW-1:0]   idx_e, lim_e;
    logic            last_elem;

    // register writes and derived values
    always_comb begin
        rs_next  = rs_reg;
        nr_next  = nr_reg;
        blr_next = blr_reg;
        cfg_hit  = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RING_SIZE: begin
                    rs_next = cfg_wdata[RS_W-1:0];
                    cfg_hit = 1'b1;
                end
                CFG_NODE_RANK: begin
                    nr_next = cfg_wdata[NR_W-1:0];
                    cfg_hit = 1'b1;
                end
                CFG_BLOCK_LEN: begin
                    blr_next = cfg_wdata[BL_W-1:0];
                    cfg_hit  = 1'b1;
                end
                default: ;
            endcase
        end
        if (rs_next < 5'd2) p8 = 8'd2;
        else if ({3'b0, rs_next} > 8'(MAX_RANKS)) p8 = 8'(MAX_RANKS);
        else p8 = {3'b0, rs_next};
        if (blr_next == '0) b13 = 13'd1;
        else if ({4'b0, blr_next} > 13'(MAX_BLOCK)) b13 = 13'(MAX_BLOCK);
        else b13 = {4'b0, blr_next};
        // rank modulo ring size, four restoring steps
        rem = {8'b0, nr_next};
        for (int i = 3; i >= 0; i--) begin
            if (rem >= ({4'b0, p8} << i)) rem = rem - ({4'b0, p8} << i);
        end
        p_next   = p8[PW-1:0];
        bl_next  = b13[BW-1:0];
        r_next   = rem[RW-1:0];
        lim_next = LW'(p_next * bl_next);
    end

    // address decode
    always_comb begin
        r_t   = TW'(r_reg);
        p_t   = TW'(p_reg);
        s_t   = TW'(step_reg);
        t0    = r_t + p_t - TW'(1) - s_t;
        if (t0 >= p_t) t0 = t0 - p_t;
        t1    = r_t + p_t - s_t;
        if (t1 >= p_t) t1 = t1 - p_t;
        step_inc  = s_t + TW'(1);
        last_elem = ({1'b0, recv_reg} + (BW+1)'(1)) >= {1'b0, bl_reg};
        idx_e = EW'(s_elem_index);
        lim_e = EW'(lim_reg);
        ctl   = '0;
        blk   = r_reg;
        cnt   = own_reg;
        case (s_kind)
            KIND_LOAD: begin
                if (idx_e < lim_e) ctl.op = OP_LOAD;
            end
            KIND_SEND: begin
                if (own_reg < bl_reg) begin
                    ctl.op = OP_SEND;
                    ctl.rd = 1'b1;
                end
            end
            KIND_RECV: begin
                cnt = recv_reg;
                if (!phase_reg) begin
                    blk    = t0[RW-1:0];
                    ctl.op = OP_RSUM;
                    ctl.rd = 1'b1;
                end else begin
                    blk      = t1[RW-1:0];
                    ctl.op   = OP_GATH;
                    ctl.fwd  = !(step_inc >= p_t);
                    ctl.done = (step_inc >= p_t) && last_elem;
                end
            end
            default: ;
        endcase
        off = OW'(blk) * OW'(bl_reg) + OW'(cnt);
        pos = (ctl.op == OP_LOAD) ? idx_e[AW-1:0] : off[AW-1:0];
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            rs_reg    <= RS_W'(2);
            nr_reg    <= '0;
            blr_reg   <= BL_W'(1);
            p_reg     <= PW'(2);
            bl_reg    <= BW'(1);
            r_reg     <= '0;
            lim_reg   <= LW'(2);
            phase_reg <= 1'b0;
            step_reg  <= '0;
            recv_reg  <= '0;
            own_reg   <= '0;
        end else begin
            rs_reg  <= rs_next;
            nr_reg  <= nr_next;
            blr_reg <= blr_next;
            p_reg   <= p_next;
            bl_reg  <= bl_next;
            r_reg   <= r_next;
            lim_reg <= lim_next;
            if (cfg_hit) begin
                phase_reg <= 1'b0;
                step_reg  <= '0;
                recv_reg  <= '0;
                own_reg   <= '0;
            end else if (accept) begin
                case (ctl.op)
                    OP_SEND: own_reg <= own_reg + BW'(1);
                    OP_RSUM, OP_GATH: begin
                        if (!last_elem) begin
                            recv_reg <= recv_reg + BW'(1);
                        end else begin
                            recv_reg <= '0;
                            if (!phase_reg) begin
                                if (step_inc >= p_t - TW'(1)) begin
                                    step_reg  <= '0;
                                    phase_reg <= 1'b1;
                                end else begin
                                    step_reg <= step_inc[PW-1:0];
                                end
                            end else if (step_inc >= p_t) begin
                                // round complete
                                step_reg  <= '0;
                                phase_reg <= 1'b0;
                                own_reg   <= '0;
                            end else begin
                                step_reg <= step_inc[PW-1:0];
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/rar_fadd.sv
// Three-stage IEEE single-precision adder, round to nearest even,
// subnormals kept. Stages advance on en. No package dependency.
`default_nettype none

module rar_fadd (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic [31:0]      sum
);

    // stage 1: specials, swap, align
    logic        nan_a, nan_b, inf_a, inf_b, a_big;
    logic [31:0] x, y, spec_val;
    logic        spec;
    logic [7:0]  ex, ey, d;
    logic [4:0]  d_sat;
    logic [26:0] mx, my, my_sh;
    logic [27:0] mask;
    logic        sticky;

    logic        s2_spec_reg, s2_sign_reg, s2_sub_reg;
    logic [31:0] s2_sval_reg;
    logic [7:0]  s2_ex_reg;
    logic [26:0] s2_mx_reg, s2_my_reg;

    // stage 2: add and leading-zero count
    logic [27:0] add;
    logic [4:0]  lz;

    logic        s3_spec_reg, s3_sign_reg, s3_sub_reg;
    logic [31:0] s3_sval_reg;
    logic [7:0]  s3_ex_reg;
    logic [27:0] s3_sum_reg;
    logic [4:0]  s3_lz_reg;

    // stage 3: normalize and round
    logic [26:0] n;
    logic [8:0]  e;
    logic [4:0]  sh;
    logic [7:0]  cap, e_enc;
    logic        up;
    logic [30:0] rnd;
    logic [31:0] res;
    logic [31:0] sum_reg;

    always_comb begin
        nan_a = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        nan_b = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        inf_a = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        inf_b = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        spec  = 1'b1;
        if (nan_a) spec_val = a | 32'h0040_0000;
        else if (nan_b) spec_val = b | 32'h0040_0000;
        else if (inf_a && inf_b && (a[31] != b[31])) spec_val = 32'hFFC0_0000;
        else if (inf_a) spec_val = a;
        else if (inf_b) spec_val = b;
        else begin
            spec     = 1'b0;
            spec_val = '0;
        end
        a_big = a[30:0] >= b[30:0];
        x     = a_big ? a : b;
        y     = a_big ? b : a;
        ex    = (x[30:23] == '0) ? 8'd1 : x[30:23];
        ey    = (y[30:23] == '0) ? 8'd1 : y[30:23];
        mx    = {x[30:23] != '0, x[22:0], 3'b000};
        my    = {y[30:23] != '0, y[22:0], 3'b000};
        d     = ex - ey;
        d_sat = (d > 8'd26) ? 5'd27 : d[4:0];
        mask  = (28'd1 << d_sat) - 28'd1;
        sticky = |(my & mask[26:0]);
        my_sh  = (my >> d_sat) | {26'b0, sticky};
    end

    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] c;
        c = 5'd28;
        for (int i = 0; i < 28; i++) begin
            if (v[i]) c = 5'(27 - i);
        end
        return c;
    endfunction

    always_comb begin
        add = s2_sub_reg ? ({1'b0, s2_mx_reg} - {1'b0, s2_my_reg})
                         : ({1'b0, s2_mx_reg} + {1'b0, s2_my_reg});
        lz  = lzc28(add);
    end

    always_comb begin
        n   = '0;
        e   = '0;
        sh  = '0;
        cap = s3_ex_reg - 8'd1;
        if (s3_sum_reg[27]) begin
            n = {s3_sum_reg[27:2], s3_sum_reg[1] | s3_sum_reg[0]};
            e = {1'b0, s3_ex_reg} + 9'd1;
        end else begin
            sh = s3_lz_reg - 5'd1;
            if ({3'b0, sh} > cap) sh = cap[4:0];
            n = s3_sum_reg[26:0] << sh;
            e = {1'b0, s3_ex_reg} - {4'b0, sh};
        end
        e_enc = n[26] ? e[7:0] : 8'd0;
        up    = n[2] & (n[1] | n[0] | n[3]);
        rnd   = {e_enc, n[25:3]} + {30'b0, up};
        if (s3_spec_reg) res = s3_sval_reg;
        else if (s3_sum_reg == '0) res = {s3_sub_reg ? 1'b0 : s3_sign_reg, 31'b0};
        else if (e >= 9'd255) res = {s3_sign_reg, 8'hFF, 23'b0};
        else res = {s3_sign_reg, rnd};
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s2_spec_reg <= spec;
            s2_sval_reg <= spec_val;
            s2_sign_reg <= x[31];
            s2_sub_reg  <= a[31] ^ b[31];
            s2_ex_reg   <= ex;
            s2_mx_reg   <= mx;
            s2_my_reg   <= my_sh;
            s3_spec_reg <= s2_spec_reg;
            s3_sval_reg <= s2_sval_reg;
            s3_sign_reg <= s2_sign_reg;
            s3_sub_reg  <= s2_sub_reg;
            s3_ex_reg   <= s2_ex_reg;
            s3_sum_reg  <= add;
            s3_lz_reg   <= lz;
            sum_reg     <= res;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

// File: hdl/rar_vecmem.sv
// Local vector store: one synchronous read port with registered data,
// one write port. No package dependency.
`default_nettype none

module rar_vecmem #(
    parameter int AW    = 12,
    parameter int DEPTH = 4096
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [31:0]        rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [31:0]   wr_data
);

    logic [31:0] mem_array [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) mem_array[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem_array[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hdl/ring_allreduce_node_top.sv
// One rank of a ring all-reduce summing single-precision floats. Input words
// are loads into the local vector, own-block sends, or words received from the
// upstream rank; each accepted word gives at most one output word carrying a
// downstream send and/or a reduced result. The block takes one word per clock
// unless the interlock or a stalled output holds it: a word is read from the
// local vector at accept, passes three adder stages and is written back from
// st4, landing in the output register at the same edge. Throughput is set by
// the single read and single write port of the vector store; a word that reads
// an entry still being updated in the pipeline (for example an own send right
// after the load of the same index) waits until that write is made. Config
// writes restart the round and keep the vector; there is no clearing pass
// after reset, unwritten entries read as whatever the memory holds. Adds round
// to nearest even with subnormals; a NaN in the stored operand wins over one in
// the received word. Depends on rar_pkg, rar_seq, rar_fadd, rar_vecmem.
`default_nettype none

module ring_allreduce_node_top import rar_pkg::*; #(
    parameter int MAX_RANKS = MAX_RANKS_DEF,
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // config
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input words
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [KIND_W-1:0]     s_kind,
    input  wire logic [IDX_W-1:0]      s_elem_index,
    input  wire logic [VAL_W-1:0]      s_elem_value,
    // output words
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_send_valid,
    output logic [VAL_W-1:0]           m_send_value,
    output logic                       m_result_valid,
    output logic [IDX_W-1:0]           m_result_index,
    output logic [VAL_W-1:0]           m_result_value,
    output logic                       m_done_res
);

    localparam int DEPTH = MAX_RANKS * MAX_BLOCK;
    localparam int AW    = $clog2(DEPTH);

    typedef struct packed {
        logic             vld;
        ctl_t             ctl;
        logic [AW-1:0]    addr;
        logic [VAL_W-1:0] val;
    } item_t;

    // st1: read data arrives; st2/st3: adder; st4: write back, to output
    item_t st1_reg, st1_next;
    item_t st2_reg, st2_next;
    item_t st3_reg, st4_reg;

    ctl_t              ctl;
    logic [AW-1:0]     pos;
    logic              en, hazard, accept;
    logic              st4_out, out_load;
    logic [VAL_W-1:0]  mem_rdata, fsum, wr_data;
    logic              wr_en;
    logic [AW+IDX_W-1:0] ridx_wide;

    logic             m_valid_reg;
    logic             m_send_valid_reg;
    logic [VAL_W-1:0] m_send_value_reg;
    logic             m_result_valid_reg;
    logic [IDX_W-1:0] m_result_index_reg;
    logic [VAL_W-1:0] m_result_value_reg;
    logic             m_done_res_reg;

    rar_seq #(
        .MAX_RANKS (MAX_RANKS),
        .MAX_BLOCK (MAX_BLOCK),
        .AW        (AW)
    ) u_seq (
        .clk          (aclk),
        .rstn         (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .accept       (accept),
        .s_kind       (s_kind),
        .s_elem_index (s_elem_index),
        .ctl          (ctl),
        .pos          (pos)
    );

    rar_vecmem #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (aclk),
        .rd_en   (en),
        .rd_addr (pos),
        .rd_data (mem_rdata),
        .wr_en   (wr_en),
        .wr_addr (st4_reg.addr),
        .wr_data (wr_data)
    );

    rar_fadd u_fadd (
        .clk (aclk),
        .en  (en),
        .a   (mem_rdata),
        .b   (st1_reg.val),
        .sum (fsum)
    );

    // whole pipe holds only when a finished word cannot leave
    assign st4_out = st4_reg.vld && (st4_reg.ctl.op == OP_SEND ||
                     st4_reg.ctl.op == OP_RSUM || st4_reg.ctl.op == OP_GATH);
    assign en       = !(st4_out && m_valid_reg && !m_ready);
    assign out_load = en && st4_out;

    // read-after-write interlock against every write still in flight
    assign hazard = ctl.rd && (
        (st1_reg.vld && op_writes(st1_reg.ctl.op) && st1_reg.addr == pos) ||
        (st2_reg.vld && op_writes(st2_reg.ctl.op) && st2_reg.addr == pos) ||
        (st3_reg.vld && op_writes(st3_reg.ctl.op) && st3_reg.addr == pos) ||
        (st4_reg.vld && op_writes(st4_reg.ctl.op) && st4_reg.addr == pos));

    assign s_ready = en && !hazard;
    assign accept  = s_valid && s_ready;

    always_comb begin
        st1_next = '0;
        if (accept && ctl.op != OP_NONE) begin
            st1_next.vld  = 1'b1;
            st1_next.ctl  = ctl;
            st1_next.addr = pos;
            st1_next.val  = s_elem_value;
        end
        st2_next = st1_reg;
        // own sends carry the stored word from here on
        if (st1_reg.ctl.op == OP_SEND) st2_next.val = mem_rdata;
    end

    assign wr_en   = en && st4_reg.vld && op_writes(st4_reg.ctl.op);
    assign wr_data = (st4_reg.ctl.op == OP_RSUM) ? fsum : st4_reg.val;
    assign ridx_wide = {{IDX_W{1'b0}}, st4_reg.addr};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_reg <= '0;
            st2_reg <= '0;
            st3_reg <= '0;
            st4_reg <= '0;
        end else if (en) begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st2_reg;
            st4_reg <= st3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_send_valid_reg   <= 1'b0;
            m_send_value_reg   <= '0;
            m_result_valid_reg <= 1'b0;
            m_result_index_reg <= '0;
            m_result_value_reg <= '0;
            m_done_res_reg     <= 1'b0;
            case (st4_reg.ctl.op)
                OP_SEND: begin
                    m_send_valid_reg <= 1'b1;
                    m_send_value_reg <= st4_reg.val;
                end
                OP_RSUM: begin
                    m_send_valid_reg <= 1'b1;
                    m_send_value_reg <= fsum;
                end
                OP_GATH: begin
                    m_send_valid_reg   <= st4_reg.ctl.fwd;
                    m_send_value_reg   <= st4_reg.ctl.fwd ? st4_reg.val : '0;
                    m_result_valid_reg <= 1'b1;
                    m_result_index_reg <= ridx_wide[IDX_W-1:0];
                    m_result_value_reg <= st4_reg.val;
                    m_done_res_reg     <= st4_reg.ctl.done;
                end
                default: ;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_send_valid   = m_send_valid_reg;
    assign m_send_value   = m_send_value_reg;
    assign m_result_valid = m_result_valid_reg;
    assign m_result_index = m_result_index_reg;
    assign m_result_value = m_result_value_reg;
    assign m_done_res     = m_done_res_reg;

endmodule

`default_nettype wire

// File: hdl/rar_checker.sv
// Port-level checks for the ring all-reduce node, bound to the top level.
// Depends on rar_pkg and ring_allreduce_node_top.
`default_nettype none

module rar_checker import rar_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  cfg_wr_en,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic [KIND_W-1:0]     s_kind,
    input wire logic [IDX_W-1:0]      s_elem_index,
    input wire logic [VAL_W-1:0]      s_elem_value,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic                  m_send_valid,
    input wire logic [VAL_W-1:0]      m_send_value,
    input wire logic                  m_result_valid,
    input wire logic [IDX_W-1:0]      m_result_index,
    input wire logic [VAL_W-1:0]      m_result_value,
    input wire logic                  m_done_res
);

    // stalled output word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_send_value) &&
        $stable(m_result_value) && $stable(m_result_index))
        else $error("output word changed while stalled");

    a_send_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_send_valid |-> m_send_value == '0)
        else $error("send value not zero without send");

    a_res_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result_valid |->
        m_result_index == '0 && m_result_value == '0 && !m_done_res)
        else $error("result fields set without result");

    // last word of a round is the echo step: result, no forward
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_result_valid && !m_send_valid)
        else $error("done word forwarded or without result");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind ring_allreduce_node_top rar_checker u_rar_checker (.*);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for ring_allreduce_node_top: rounds of loads, own sends
// and upstream words, checked against an in-bench all-reduce predictor.
// Depends on rar_pkg and the RTL under hdl.
`default_nettype none

module testbench;
    import rar_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NOISE = 2'd3;  // undefined kind, must be ignored
    localparam int VEC_WORDS = MAX_RANKS_DEF * MAX_BLOCK_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic             send_valid;
        logic [VAL_W-1:0] send_value;
        logic             result_valid;
        logic [IDX_W-1:0] result_index;
        logic [VAL_W-1:0] result_value;
        logic             done_res;
    } node_word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_RING_SIZE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [KIND_W-1:0]     s_kind = KIND_LOAD;
    logic [IDX_W-1:0]      s_elem_index = '0;
    logic [VAL_W-1:0]      s_elem_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_send_valid;
    logic [VAL_W-1:0]      m_send_value;
    logic                  m_result_valid;
    logic [IDX_W-1:0]      m_result_index;
    logic [VAL_W-1:0]      m_result_value;
    logic                  m_done_res;

    ring_allreduce_node_top u_dut (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_kind, .s_elem_index, .s_elem_value,
        .m_valid, .m_ready, .m_send_valid, .m_send_value, .m_result_valid,
        .m_result_index, .m_result_value, .m_done_res
    );

    always #2 aclk = ~aclk;

    // predictor copy of the node
    logic [RS_W-1:0]  ring_size_reg;
    logic [NR_W-1:0]  node_rank_reg;
    logic [BL_W-1:0]  block_len_reg;
    logic [VAL_W-1:0] vec_copy [VEC_WORDS];
    logic             gather_phase;
    int               step_no, recv_no, own_sent;

    node_word_t pending_words[$];
    int  err_count = 0;
    int  words_in = 0, words_out = 0, rounds_done = 0;
    int  cycle_no = 0;
    bit  calm = 0;         // no idling on either side while set
    int  m_hold = 0;

    function automatic int ring_eff();
        if (ring_size_reg < 2) return 2;
        if (ring_size_reg > MAX_RANKS_DEF) return MAX_RANKS_DEF;
        return ring_size_reg;
    endfunction

    function automatic int blk_eff();
        if (block_len_reg < 1) return 1;
        if (block_len_reg > MAX_BLOCK_DEF) return MAX_BLOCK_DEF;
        return block_len_reg;
    endfunction

    function automatic void restart_round();
        gather_phase = 1'b0;
        step_no = 0;
        recv_no = 0;
        own_sent = 0;
    endfunction

    // IEEE single add, round to nearest even, subnormals kept.
    // NaN in the stored operand (a) wins; inf-inf gives the default NaN.
    function automatic logic [31:0] fp32_sum(logic [31:0] a, logic [31:0] b);
        logic [31:0] tmp;
        logic [27:0] ma, mb, mr, low;
        logic [24:0] mant;
        int ea, eb, er, d;
        logic sr;
        if (a[30:23] == 8'hff && a[22:0] != 0) return a | 32'h0040_0000;
        if (b[30:23] == 8'hff && b[22:0] != 0) return b | 32'h0040_0000;
        if (a[30:23] == 8'hff) begin
            if (b[30:23] == 8'hff && a[31] != b[31]) return 32'hffc0_0000;
            return a;
        end
        if (b[30:23] == 8'hff) return b;
        if (a[30:0] < b[30:0]) begin
            tmp = a; a = b; b = tmp;
        end
        ma = {1'b0, a[30:23] != 0, a[22:0], 3'b0};
        mb = {1'b0, b[30:23] != 0, b[22:0], 3'b0};
        ea = (a[30:23] == 0) ? 1 : a[30:23];
        eb = (b[30:23] == 0) ? 1 : b[30:23];
        sr = a[31];
        d = ea - eb;
        if (d > 27) begin
            mb = {27'b0, |mb};
        end else if (d > 0) begin
            low = mb & ((28'd1 << d) - 1);
            mb = (mb >> d) | {27'b0, |low};
        end
        mr = (a[31] == b[31]) ? ma + mb : ma - mb;
        if (mr == 0) return {a[31] & b[31], 31'b0};
        er = ea;
        if (mr[27]) begin
            mr = (mr >> 1) | {27'b0, mr[0]};
            er++;
        end else begin
            while (!mr[26] && er > 1) begin
                mr = mr << 1;
                er--;
            end
        end
        mant = {1'b0, mr[26:3]};
        if (mr[2] && (mr[1] || mr[0] || mant[0])) mant++;
        if (mant[24]) begin
            mant = mant >> 1;
            er++;
        end
        if (er >= 255) return {sr, 8'hff, 23'b0};
        return {sr, mant[23] ? er[7:0] : 8'd0, mant[22:0]};
    endfunction

    // Advance the predictor by one accepted word; queue the output word if any.
    function automatic void predict_node(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                                         logic [VAL_W-1:0] val);
        int p, bl, r, blk, pos;
        node_word_t w;
        p = ring_eff();
        bl = blk_eff();
        r = node_rank_reg % p;
        w = '0;
        case (kind)
            KIND_LOAD: begin
                if (idx < p * bl) vec_copy[idx] = val;
            end
            KIND_SEND: begin
                if (own_sent < bl) begin
                    pos = r * bl + own_sent;
                    own_sent++;
                    w.send_valid = 1'b1;
                    w.send_value = vec_copy[pos];
                    pending_words.push_back(w);
                end
            end
            KIND_RECV: begin
                if (!gather_phase) begin
                    blk = (r + 2 * p - 1 - step_no) % p;
                    pos = blk * bl + recv_no;
                    vec_copy[pos] = fp32_sum(vec_copy[pos], val);
                    w.send_valid = 1'b1;
                    w.send_value = vec_copy[pos];
                    recv_no++;
                    if (recv_no >= bl) begin
                        recv_no = 0;
                        step_no++;
                        if (step_no >= p - 1) begin
                            step_no = 0;
                            gather_phase = 1'b1;
                        end
                    end
                end else begin
                    blk = (r + 2 * p - step_no) % p;
                    pos = blk * bl + recv_no;
                    vec_copy[pos] = val;
                    if (step_no + 1 < p) begin
                        w.send_valid = 1'b1;
                        w.send_value = val;
                    end
                    w.result_valid = 1'b1;
                    w.result_index = pos[IDX_W-1:0];
                    w.result_value = val;
                    w.done_res = (step_no + 1 >= p) && (recv_no + 1 >= bl);
                    recv_no++;
                    if (recv_no >= bl) begin
                        recv_no = 0;
                        step_no++;
                        if (step_no >= p) begin
                            restart_round();
                            rounds_done++;
                        end
                    end
                end
                pending_words.push_back(w);
            end
            default: ;
        endcase
    endfunction

    // gap length for either side; calm stretches have none
    function automatic int idle_draw();
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    // varied float bits: raw, moderate, and the special encodings
    function automatic logic [31:0] float_pick();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return {$urandom_range(0, 1) == 1, 8'hff, 23'b0};
            3: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
            4: return {$urandom_range(0, 1) == 1, 8'hfe, 23'($urandom)};
            5, 6: return $urandom;
            default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(118, 136)),
                             23'($urandom)};
        endcase
    endfunction

    // valid drops only ahead of a gap or an idle stretch; back-to-back words
    // replace the payload at the negedge after acceptance
    task automatic send_word(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                             logic [VAL_W-1:0] val);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_elem_index <= idx;
        s_elem_value <= val;
        do @(posedge aclk); while (!s_ready);
        predict_node(kind, idx, val);
        words_in++;
        @(negedge aclk);
    endtask

    // registers change only with the node drained; loads give no word back,
    // so allow the pipeline its latency before writing
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_RING_SIZE: ring_size_reg = data[RS_W-1:0];
            CFG_NODE_RANK: node_rank_reg = data[NR_W-1:0];
            CFG_BLOCK_LEN: block_len_reg = data[BL_W-1:0];
            default: ;
        endcase
        restart_round();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_ring(int rs, int nr, int bl);
        cfg_write(CFG_RING_SIZE, CFG_DATA_W'(rs));
        cfg_write(CFG_NODE_RANK, CFG_DATA_W'(nr));
        cfg_write(CFG_BLOCK_LEN, CFG_DATA_W'(bl));
    endtask

    // Fill the active part of the vector, then mix own sends with upstream words, the
    // latter capped at recv_cap; noisy adds ignored and harmless items along the way.
    task automatic run_round(int recv_cap, bit noisy);
        int p, bl, n, sends_left, recvs_left;
        p = ring_eff();
        bl = blk_eff();
        n = p * bl;
        for (int i = 0; i < n; i++) send_word(KIND_LOAD, IDX_W'(i), float_pick());
        sends_left = bl;
        recvs_left = (2 * p - 1) * bl;
        if (recvs_left > recv_cap) recvs_left = recv_cap;
        while (sends_left > 0 || recvs_left > 0) begin
            if (noisy && $urandom_range(0, 15) == 0) begin
                case ($urandom_range(0, 2))
                    0: send_word(KIND_NOISE, IDX_W'($urandom), $urandom);
                    1: if (n < VEC_WORDS)
                        send_word(KIND_LOAD, IDX_W'($urandom_range(n, VEC_WORDS - 1)), $urandom);
                    default: send_word(KIND_LOAD, IDX_W'($urandom_range(0, n - 1)), float_pick());
                endcase
            end else if (sends_left > 0 && (recvs_left == 0 || $urandom_range(0, 2) == 0)) begin
                send_word(KIND_SEND, IDX_W'($urandom), $urandom);
                sends_left--;
            end else begin
                send_word(KIND_RECV, IDX_W'($urandom), float_pick());
                recvs_left--;
            end
        end
        // surplus own send, ignored only if the round was cut short
        if (noisy && $urandom_range(0, 3) == 0) send_word(KIND_SEND, '0, $urandom);
    endtask

    // ---- tests ----

    // Reset values: two ranks, one element each, extreme values.
    task automatic test_default_round();
        send_word(KIND_LOAD, 12'd0, 32'h7f7f_ffff);
        send_word(KIND_LOAD, 12'd1, 32'hffff_ffff);
        send_word(KIND_SEND, 12'hfff, 32'hffff_ffff);
        send_word(KIND_RECV, 12'd0, 32'h7f7f_ffff);   // stored operand is NaN, the sum stays NaN
        send_word(KIND_RECV, 12'd0, 32'h0000_0001);
        send_word(KIND_RECV, 12'd0, 32'h8000_0000);   // echo step, round done
    endtask

    // Ignored items: beyond the vector, surplus sends, undefined kind.
    task automatic test_ignored_items();
        send_word(KIND_LOAD, 12'hfff, 32'h1234_5678);
        send_word(KIND_LOAD, 12'd2, 32'hdead_beef);
        send_word(KIND_NOISE, 12'hfff, 32'hffff_ffff);
        send_word(KIND_LOAD, 12'd0, 32'h3f80_0000);
        send_word(KIND_LOAD, 12'd1, 32'hbf80_0000);
        send_word(KIND_SEND, 12'd0, 32'h0);
        send_word(KIND_SEND, 12'd0, 32'h0);
        send_word(KIND_RECV, 12'd0, 32'h7f80_0000);
        send_word(KIND_RECV, 12'd0, 32'hff80_0000);   // gather step: -inf stored and forwarded, no add
    endtask

    // Register values outside range, and a rank at or above the ring size.
    task automatic test_register_limits();
        set_ring(0, 0, 0);
        run_round(1000, 0);
        set_ring(31, 15, 2);
        run_round(1000, 0);
        set_ring(3, 14, 3);
        run_round(1000, 0);
        set_ring(1, 0, 511);
        run_round(6, 0);
    endtask

    // Largest block with the highest rank: top entries of the vector.
    task automatic test_largest_block();
        set_ring(16, 15, 256);
        for (int i = 0; i < 6; i++) send_word(KIND_LOAD, IDX_W'(3840 + i), $urandom);
        send_word(KIND_LOAD, 12'hfff, 32'hffff_ffff);
        for (int i = 0; i < 6; i++) send_word(KIND_SEND, '0, '0);
    endtask

    // Largest ring; a round left unfinished is restarted by the next write.
    task automatic test_full_ring();
        set_ring(16, 7, 1);
        run_round(1000, 0);
        set_ring(5, 2, 2);
        run_round(7, 0);
        cfg_write(CFG_NODE_RANK, 9'd1);
        run_round(1000, 0);
    endtask

    task automatic test_random_rounds();
        while (words_in < 1650) begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 7) == 0)
                cfg_write(CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom_range(0, 6)));
            else
                set_ring($urandom_range(2, 5), $urandom_range(0, 15), $urandom_range(1, 4));
            run_round(($urandom_range(0, 5) == 0) ? $urandom_range(0, 12) : 1000, 1);
        end
        calm = 0;
    endtask

    // ---- output side ----

    always @(negedge aclk) begin
        if (m_hold > 0) begin
            m_ready <= 1'b0;
            m_hold  <= m_hold - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        node_word_t want;
        cycle_no <= cycle_no + 1;
        if (aresetn && m_valid && m_ready) begin
            m_hold <= idle_draw();
            words_out++;
            if (pending_words.size() == 0) begin
                $error("output word with nothing expected");
                err_count++;
            end else begin
                want = pending_words.pop_front();
                if (m_send_valid !== want.send_valid) begin
                    $error("send_valid exp %0h got %0h", want.send_valid, m_send_valid);
                    err_count++;
                end
                if (m_send_value !== want.send_value) begin
                    $error("send_value exp %08h got %08h", want.send_value, m_send_value);
                    err_count++;
                end
                if (m_result_valid !== want.result_valid) begin
                    $error("result_valid exp %0h got %0h", want.result_valid, m_result_valid);
                    err_count++;
                end
                if (m_result_index !== want.result_index) begin
                    $error("result_index exp %0d got %0d", want.result_index, m_result_index);
                    err_count++;
                end
                if (m_result_value !== want.result_value) begin
                    $error("result_value exp %08h got %08h", want.result_value, m_result_value);
                    err_count++;
                end
                if (m_done_res !== want.done_res) begin
                    $error("done_res exp %0h got %0h", want.done_res, m_done_res);
                    err_count++;
                end
            end
        end
        if (cycle_no >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_no, pending_words.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        ring_size_reg = 2;
        node_rank_reg = 0;
        block_len_reg = 1;
        restart_round();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_default_round();
        test_ignored_items();
        test_register_limits();
        test_largest_block();
        test_full_ring();
        test_random_rounds();

        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        $display("covered %0d input words, %0d output words, %0d complete rounds",
                 words_in, words_out, rounds_done);
        $display("mismatches: %0d", err_count);
        if (err_count == 0 && pending_words.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
